### hw/rtl/vss_pkg.sv
// Shared types and constants for the vorticity stencil stream.
`timescale 1ns / 1ps

package vss_pkg;

    // Row handling is fixed by the frame size limit.
    localparam int ROW_BITS      = 12;
    localparam int ROWS_LIMIT    = 4096;

    // Configuration register layout.
    localparam int CFG_COLS_BITS = 11;
    localparam int CFG_ROWS_BITS = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;

    // Reset values of the configuration registers.
    localparam int COLS_RESET    = 1024;
    localparam int ROWS_RESET    = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } cfg_reg_t;

    // Per-item control that travels from the scan counters to the curl stage.
    typedef struct packed {
        logic                emit;     // cell one row up is interior
        logic                last;     // last interior cell of the frame
        logic                has_nxt;  // right-hand neighbour lies inside the row
        logic [ROW_BITS-1:0] row;      // row of the interior cell
    } scan_flags_t;

endpackage

### hw/rtl/vss_line_store.sv
// Line buffers for the ux row pair and the previous uy row, with write bypass.
`timescale 1ns / 1ps

module vss_line_store #(
    parameter int DEPTH     = 1024,
    parameter int S_BITS    = 16,
    parameter int ADDR_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [ADDR_BITS-1:0]   rd_col,
    input  logic [ADDR_BITS-1:0]   rd_nxt,
    input  logic                   wr_en,
    input  logic [ADDR_BITS-1:0]   wr_col,
    input  logic [2*S_BITS-1:0]    wr_ux_pair,
    input  logic [S_BITS-1:0]      wr_uy,
    output logic [2*S_BITS-1:0]    ux_pair,
    output logic [S_BITS-1:0]      uy_cur,
    output logic [S_BITS-1:0]      uy_nxt
);

    // Each ux entry holds {older row, newer row} for one column.
    logic [2*S_BITS-1:0] ux_line_mem [DEPTH];
    logic [S_BITS-1:0]   uy_line_mem [DEPTH];

    logic [2*S_BITS-1:0] ux_q_reg;
    logic [S_BITS-1:0]   uy_cur_q_reg;
    logic [S_BITS-1:0]   uy_nxt_q_reg;

    logic [2*S_BITS-1:0] fwd_ux_reg;
    logic [S_BITS-1:0]   fwd_uy_reg;
    logic                fwd_col_reg;
    logic                fwd_nxt_reg;

    // Synchronous write and registered read of both line buffers.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ux_line_mem[wr_col] <= wr_ux_pair;
            uy_line_mem[wr_col] <= wr_uy;
        end
        if (rd_en)
        begin
            ux_q_reg     <= ux_line_mem[rd_col];
            uy_cur_q_reg <= uy_line_mem[rd_col];
            uy_nxt_q_reg <= uy_line_mem[rd_nxt];
            fwd_ux_reg   <= wr_ux_pair;
            fwd_uy_reg   <= wr_uy;
        end
    end

    // A read that meets a write to the same entry on the same edge takes the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_col_reg <= 1'b0;
            fwd_nxt_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_col_reg <= wr_en && (wr_col == rd_col);
            fwd_nxt_reg <= wr_en && (wr_col == rd_nxt);
        end
    end

    assign ux_pair = fwd_col_reg ? fwd_ux_reg : ux_q_reg;
    assign uy_cur  = fwd_col_reg ? fwd_uy_reg : uy_cur_q_reg;
    assign uy_nxt  = fwd_nxt_reg ? fwd_uy_reg : uy_nxt_q_reg;

endmodule

### hw/rtl/vss_scan_ctrl.sv
// Frame size registers and raster position counters that address the line buffers.
`timescale 1ns / 1ps

module vss_scan_ctrl #(
    parameter int MAX_COLS  = 1024,
    parameter int COL_BITS  = 10,
    parameter int CCNT_BITS = 11
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [vss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_accept,
    input  logic                                frame_start,
    output logic [COL_BITS-1:0]                 rd_col,
    output logic [COL_BITS-1:0]                 rd_nxt,
    output vss_pkg::scan_flags_t                flags
);

    localparam int ROWS_BITS  = vss_pkg::CFG_ROWS_BITS;
    localparam int COLS_INIT  = (vss_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                                : vss_pkg::COLS_RESET;

    logic [CCNT_BITS-1:0]             cols_reg, cols_next;
    logic [ROWS_BITS-1:0]             rows_reg, rows_next;
    logic [COL_BITS-1:0]              col_cnt_reg, col_cnt_next;
    logic [vss_pkg::ROW_BITS-1:0]     row_cnt_reg, row_cnt_next;

    logic [vss_pkg::CFG_COLS_BITS-1:0] cols_wr;
    logic [ROWS_BITS-1:0]              rows_wr;
    logic [CCNT_BITS-1:0]              c_clamp;
    logic [CCNT_BITS-1:0]              c0;
    logic [CCNT_BITS-1:0]              c_inc;
    logic [ROWS_BITS-1:0]              r_clamp;
    logic [ROWS_BITS-1:0]              r0;
    logic [ROWS_BITS-1:0]              r_inc;
    logic                              has_nxt;

    // Register writes keep the clamped frame size.
    assign cols_wr = cfg_data[vss_pkg::CFG_COLS_BITS-1:0];
    assign rows_wr = cfg_data[ROWS_BITS-1:0];

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                vss_pkg::REG_FRAME_COLS:
                begin
                    if (32'(cols_wr) < 3)
                        cols_next = CCNT_BITS'(3);
                    else if (32'(cols_wr) > MAX_COLS)
                        cols_next = CCNT_BITS'(MAX_COLS);
                    else
                        cols_next = CCNT_BITS'(32'(cols_wr));
                end
                vss_pkg::REG_FRAME_ROWS:
                begin
                    if (32'(rows_wr) < 3)
                        rows_next = ROWS_BITS'(3);
                    else if (32'(rows_wr) > vss_pkg::ROWS_LIMIT)
                        rows_next = ROWS_BITS'(vss_pkg::ROWS_LIMIT);
                    else
                        rows_next = rows_wr;
                end
            endcase
        end
    end

    // Position of the arriving sample, after a frame restart or a shrunk frame.
    assign c_clamp = ({1'b0, col_cnt_reg} >= cols_reg) ? cols_reg - CCNT_BITS'(1)
                                                       : {1'b0, col_cnt_reg};
    assign c0      = frame_start ? '0 : c_clamp;
    assign r_clamp = ({1'b0, row_cnt_reg} >= rows_reg) ? rows_reg - ROWS_BITS'(1)
                                                       : {1'b0, row_cnt_reg};
    assign r0      = frame_start ? '0 : r_clamp;
    assign c_inc   = c0 + CCNT_BITS'(1);
    assign r_inc   = r0 + ROWS_BITS'(1);
    assign has_nxt = (c_inc < cols_reg);

    // Read addresses for the current column and its right-hand neighbour.
    assign rd_col = c0[COL_BITS-1:0];
    assign rd_nxt = has_nxt ? c_inc[COL_BITS-1:0] : c0[COL_BITS-1:0];

    // The cell one row up is interior when it is off every border.
    always_comb
    begin
        flags.emit    = (r0 >= ROWS_BITS'(2)) && (c0 != '0) && has_nxt;
        flags.last    = (r_inc == rows_reg) && ((c_inc + CCNT_BITS'(1)) == cols_reg);
        flags.has_nxt = has_nxt;
        flags.row     = vss_pkg::ROW_BITS'(r0 - ROWS_BITS'(1));
    end

    // Counters step on every accepted item and wrap at the frame end.
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_accept)
        begin
            if (has_nxt)
            begin
                col_cnt_next = c_inc[COL_BITS-1:0];
                row_cnt_next = r0[vss_pkg::ROW_BITS-1:0];
            end
            else
            begin
                col_cnt_next = '0;
                row_cnt_next = (r_inc >= rows_reg) ? '0 : r_inc[vss_pkg::ROW_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= CCNT_BITS'(COLS_INIT);
            rows_reg    <= ROWS_BITS'(vss_pkg::ROWS_RESET);
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

### hw/rtl/vss_curl_unit.sv
// Curl stage: combines line-buffer data, writes rows back and holds the result register.
`timescale 1ns / 1ps

module vss_curl_unit #(
    parameter int S_BITS    = 16,
    parameter int COL_BITS  = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_accept,
    input  vss_pkg::scan_flags_t               flags,
    input  logic [COL_BITS-1:0]                rd_col,
    input  logic signed [S_BITS-1:0]           ux_sample,
    input  logic signed [S_BITS-1:0]           uy_sample,
    input  logic [2*S_BITS-1:0]                ux_pair,
    input  logic [S_BITS-1:0]                  uy_cur,
    input  logic [S_BITS-1:0]                  uy_nxt,
    output logic                               s1_free,
    output logic                               wr_en,
    output logic [COL_BITS-1:0]                wr_col,
    output logic [2*S_BITS-1:0]                wr_ux_pair,
    output logic [S_BITS-1:0]                  wr_uy,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [S_BITS+1:0]           curl_value,
    output logic [vss_pkg::ROW_BITS-1:0]       center_row,
    output logic [COL_BITS-1:0]                center_col,
    output logic                               frame_last
);

    localparam int C_BITS = S_BITS + 2;

    logic                          s1_valid_reg, s1_valid_next;
    vss_pkg::scan_flags_t          s1_flags_reg;
    logic [COL_BITS-1:0]           s1_col_reg;
    logic signed [S_BITS-1:0]      s1_ux_reg;
    logic [S_BITS-1:0]             s1_uy_reg;
    logic signed [S_BITS-1:0]      window_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [C_BITS-1:0]      curl_reg;
    logic [vss_pkg::ROW_BITS-1:0]  row_reg;
    logic [COL_BITS-1:0]           col_reg;
    logic                          last_reg;

    logic                          s1_adv;
    logic signed [S_BITS-1:0]      older;
    logic signed [S_BITS-1:0]      nxt;
    logic signed [C_BITS-1:0]      dx;
    logic signed [C_BITS-1:0]      dy;
    logic signed [C_BITS-1:0]      curl;

    // The item in the curl stage moves on unless its result would meet a full output.
    assign s1_adv  = s1_valid_reg
                     && (!s1_flags_reg.emit || !out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Capture the item while its line-buffer reads are in flight.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_flags_reg <= flags;
            s1_col_reg   <= rd_col;
            s1_ux_reg    <= ux_sample;
            s1_uy_reg    <= uy_sample;
        end
    end

    // Vertical ux difference minus horizontal uy difference.
    assign older = $signed(ux_pair[2*S_BITS-1:S_BITS]);
    assign nxt   = s1_flags_reg.has_nxt ? $signed(uy_nxt) : '0;
    assign dx    = C_BITS'(s1_ux_reg) - C_BITS'(older);
    assign dy    = C_BITS'(nxt) - C_BITS'(window_reg);
    assign curl  = dx - dy;

    // Rotate the ux rows and store the new uy row entry.
    assign wr_en      = s1_adv;
    assign wr_col     = s1_col_reg;
    assign wr_ux_pair = {ux_pair[S_BITS-1:0], s1_ux_reg};
    assign wr_uy      = s1_uy_reg;

    // Output register: loads when a result leaves the curl stage.
    always_comb
    begin
        if (s1_adv && s1_flags_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_flags_reg.emit)
        begin
            curl_reg <= curl;
            row_reg  <= s1_flags_reg.row;
            col_reg  <= s1_col_reg;
            last_reg <= s1_flags_reg.last;
        end
    end

    // The window keeps the previous column's uy from the row above.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                window_reg <= $signed(uy_cur);
        end
    end

    assign out_valid  = out_valid_reg;
    assign curl_value = curl_reg;
    assign center_row = row_reg;
    assign center_col = col_reg;
    assign frame_last = last_reg;

endmodule

### hw/rtl/vorticity_stencil_stream.sv
// Top level of the streaming central-difference vorticity block.
// Usage:
//   Velocity samples (ux_sample, uy_sample) arrive in raster order on the input
//   channel (in_valid / in_ready), one item per cell; frame_start marks cell (0,0).
//   For every interior cell one result item leaves on the output channel
//   (out_valid / out_ready) with curl_value, center_row, center_col and frame_last.
//   A result for cell (r,c) is produced by the input item of cell (r+1,c).
//   out_valid rises when the result moves from the curl stage into the output
//   register, where the receiver can take it.
//   Throughput: one item per cycle while the receiver takes results; the stage
//   that reads the line-buffer RAMs and the output register each hold one item.
//   When the receiver stalls, a waiting result keeps its value; one further item
//   is taken and held, then in_ready drops until the result register drains.
//   Items without a result never wait on the receiver.
//   Frame size is set through cfg_we / cfg_index / cfg_data while the block is idle.
//   Reset clears counters, handshake state and the uy window and restores
//   1024 x 1024 frame size; line buffers are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module vorticity_stencil_stream #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [vss_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [vss_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [SAMPLE_BITS-1:0]            ux_sample,
    input  logic signed [SAMPLE_BITS-1:0]            uy_sample,
    input  logic                                     frame_start,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [SAMPLE_BITS+1:0]            curl_value,
    output logic [vss_pkg::ROW_BITS-1:0]             center_row,
    output logic [$clog2(MAX_COLS)-1:0]              center_col,
    output logic                                     frame_last
);

    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int CCNT_BITS = COL_BITS + 1;

    logic                        in_accept;
    logic                        s1_free;
    vss_pkg::scan_flags_t        flags;
    logic [COL_BITS-1:0]         rd_col;
    logic [COL_BITS-1:0]         rd_nxt;
    logic                        wr_en;
    logic [COL_BITS-1:0]         wr_col;
    logic [2*SAMPLE_BITS-1:0]    wr_ux_pair;
    logic [SAMPLE_BITS-1:0]      wr_uy;
    logic [2*SAMPLE_BITS-1:0]    ux_pair;
    logic [SAMPLE_BITS-1:0]      uy_cur;
    logic [SAMPLE_BITS-1:0]      uy_nxt;

    // Input handshake.
    assign in_ready  = s1_free;
    assign in_accept = in_valid && s1_free;

    // Frame size and raster position.
    vss_scan_ctrl #(
        .MAX_COLS  (MAX_COLS),
        .COL_BITS  (COL_BITS),
        .CCNT_BITS (CCNT_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_accept   (in_accept),
        .frame_start (frame_start),
        .rd_col      (rd_col),
        .rd_nxt      (rd_nxt),
        .flags       (flags)
    );

    // Line buffers, read on acceptance and written when the item leaves the curl stage.
    vss_line_store #(
        .DEPTH     (MAX_COLS),
        .S_BITS    (SAMPLE_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_accept),
        .rd_col     (rd_col),
        .rd_nxt     (rd_nxt),
        .wr_en      (wr_en),
        .wr_col     (wr_col),
        .wr_ux_pair (wr_ux_pair),
        .wr_uy      (wr_uy),
        .ux_pair    (ux_pair),
        .uy_cur     (uy_cur),
        .uy_nxt     (uy_nxt)
    );

    // Stencil arithmetic and output register.
    vss_curl_unit #(
        .S_BITS   (SAMPLE_BITS),
        .COL_BITS (COL_BITS)
    ) u_curl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .flags      (flags),
        .rd_col     (rd_col),
        .ux_sample  (ux_sample),
        .uy_sample  (uy_sample),
        .ux_pair    (ux_pair),
        .uy_cur     (uy_cur),
        .uy_nxt     (uy_nxt),
        .s1_free    (s1_free),
        .wr_en      (wr_en),
        .wr_col     (wr_col),
        .wr_ux_pair (wr_ux_pair),
        .wr_uy      (wr_uy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .curl_value (curl_value),
        .center_row (center_row),
        .center_col (center_col),
        .frame_last (frame_last)
    );

endmodule

### hw/rtl/vss_checker.sv
// Port-level checks for the vorticity stencil stream, bound to the top level.
`timescale 1ns / 1ps

module vss_checker #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic signed [SAMPLE_BITS+1:0]            curl_value,
    input  logic [vss_pkg::ROW_BITS-1:0]             center_row,
    input  logic [$clog2(MAX_COLS)-1:0]              center_col,
    input  logic                                     frame_last
);

    // No result is shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(curl_value)
            && $stable(center_row) && $stable(center_col) && $stable(frame_last))
        else $error("stalled result changed");

    // Results only ever describe interior cells.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> center_row != '0 && center_col != '0)
        else $error("result for a border cell");

    // A fresh result follows an accepted input item.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input item");

    // With the receiver taking results the block never holds off the sender.
    a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled although output is drained");

endmodule

bind vorticity_stencil_stream vss_checker #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vss_checker (.*);

### bench/testbench.sv
// Self-checking testbench for the streaming central-difference vorticity block.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_COLS      = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int QUIET_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int CURL_TOP      = 131071;
    localparam int CURL_BOTTOM   = -131072;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // One predicted result item.
    typedef struct packed {
        logic signed [17:0] curl;
        logic [11:0]        row;
        logic [9:0]         col;
        logic               last;
    } curl_cell_t;

    // Tracks the stencil state, predicts each curl item and checks the block's output.
    class curl_board;
        logic [10:0]        cols_reg;
        logic [12:0]        rows_reg;
        logic signed [15:0] ux_two_up [MAX_COLS];
        logic signed [15:0] ux_one_up [MAX_COLS];
        logic signed [15:0] uy_above [MAX_COLS];
        logic signed [15:0] uy_left;
        int unsigned        col_pos;
        int unsigned        row_pos;
        curl_cell_t         curl_due [$];
        int                 errors;

        function new();
            cols_reg = 11'(vss_pkg::COLS_RESET);
            rows_reg = 13'(vss_pkg::ROWS_RESET);
            for (int i = 0; i < MAX_COLS; i++)
            begin
                ux_two_up[i] = '0;
                ux_one_up[i] = '0;
                uy_above[i]  = '0;
            end
            uy_left = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function int unsigned eff_cols();
            if (cols_reg < 3)
                return 3;
            if (cols_reg > MAX_COLS)
                return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned eff_rows();
            if (rows_reg < 3)
                return 3;
            if (rows_reg > vss_pkg::ROWS_LIMIT)
                return vss_pkg::ROWS_LIMIT;
            return rows_reg;
        endfunction

        function void set_reg(vss_pkg::cfg_reg_t idx, logic [12:0] value);
            if (idx == vss_pkg::REG_FRAME_COLS)
                cols_reg = value[10:0];
            else
                rows_reg = value;
        endfunction

        function int pending();
            return curl_due.size();
        endfunction

        // Advance the stencil by one accepted sample and queue the curl it completes.
        function void take_sample(logic signed [15:0] ux, logic signed [15:0] uy, logic fs);
            int unsigned        cols;
            int unsigned        rows;
            int unsigned        r;
            int unsigned        c;
            logic signed [15:0] cur;
            logic signed [15:0] nxt;
            int                 dx;
            int                 dy;
            int                 v;
            curl_cell_t         due_item;
            cols = eff_cols();
            rows = eff_rows();
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            // A counter left beyond a shrunken frame sits on its last cell.
            if (col_pos >= cols)
                col_pos = cols - 1;
            if (row_pos >= rows)
                row_pos = rows - 1;
            r = row_pos;
            c = col_pos;

            cur = uy_above[c];
            nxt = (c + 1 < cols) ? uy_above[c + 1] : '0;
            if (c == 0)
                uy_left = '0;

            // The cell one row up is interior: emit its curl.
            if (r >= 2 && c >= 1 && c + 2 <= cols)
            begin
                dx = ux - ux_two_up[c];
                dy = nxt - uy_left;
                v  = dx - dy;
                if (v > CURL_TOP)
                    v = CURL_TOP;
                if (v < CURL_BOTTOM)
                    v = CURL_BOTTOM;
                due_item.curl = v[17:0];
                due_item.row  = 12'(r - 1);
                due_item.col  = 10'(c);
                due_item.last = (r + 1 == rows) && (c + 2 == cols);
                curl_due.push_back(due_item);
            end

            ux_two_up[c] = ux_one_up[c];
            ux_one_up[c] = ux;
            uy_above[c]  = uy;
            uy_left      = cur;

            // Raster advance with wrap at the end of the frame.
            c++;
            if (c >= cols)
            begin
                c = 0;
                r++;
                if (r >= rows)
                    r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        task flag(string msg);
            errors++;
            if (errors <= 20)
                $display("MISMATCH: %s", msg);
        endtask

        // Compare one accepted result item with the oldest prediction.
        task check_curl(logic signed [17:0] curl, logic [11:0] row, logic [9:0] col,
                        logic last);
            curl_cell_t want;
            if (curl_due.size() == 0)
            begin
                flag($sformatf("unexpected item curl %0d at (%0d,%0d)", curl, row, col));
                return;
            end
            want = curl_due.pop_front();
            if (curl !== want.curl)
                flag($sformatf("curl_value %0d, expected %0d at (%0d,%0d)",
                               curl, want.curl, want.row, want.col));
            if (row !== want.row)
                flag($sformatf("center_row %0d, expected %0d", row, want.row));
            if (col !== want.col)
                flag($sformatf("center_col %0d, expected %0d", col, want.col));
            if (last !== want.last)
                flag($sformatf("frame_last %0b, expected %0b at (%0d,%0d)",
                               last, want.last, want.row, want.col));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    vss_pkg::cfg_reg_t   cfg_index;
    logic [12:0]         cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic signed [15:0]  ux_sample;
    logic signed [15:0]  uy_sample;
    logic                frame_start;
    logic                out_valid;
    logic                out_ready;
    logic signed [17:0]  curl_value;
    logic [11:0]         center_row;
    logic [9:0]          center_col;
    logic                frame_last;

    curl_board           sb;
    bit                  gaps_on;
    int                  stall_left;
    int                  quiet_cycles;

    vorticity_stencil_stream #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ux_sample   (ux_sample),
        .uy_sample   (uy_sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curl_value  (curl_value),
        .center_row  (center_row),
        .center_col  (center_col),
        .frame_last  (frame_last)
    );

    // Clock.
    always #2 clk = ~clk;

    // Receiver: stalls in bursts at random while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result checking on every accepted output item.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_curl(curl_value, center_row, center_col, frame_last);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("vorticity_stencil_stream verification failed");
                $finish;
            end
        end
    end

    // Sample values biased towards the extremes and zero.
    function automatic logic signed [15:0] pick_sample();
        unique case ($urandom_range(0, 7))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item, wait for acceptance and hand it to the predictor.
    task automatic send_item(logic signed [15:0] ux, logic signed [15:0] uy, logic fs);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        ux_sample   <= ux;
        uy_sample   <= uy;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_sample(ux, uy, fs);
        @(negedge clk);
    endtask

    // Whole frames of random content, frame_start sometimes left to the wrap.
    task automatic send_frames(int n_frames, int extra, bit first_start);
        int  cells;
        int  total;
        logic fs;
        cells = sb.eff_cols() * sb.eff_rows();
        total = n_frames * cells + extra;
        for (int i = 0; i < total; i++)
        begin
            if (i == 0)
                fs = first_start;
            else
                fs = (i % cells == 0) && ($urandom_range(0, 2) != 0);
            send_item(pick_sample(), pick_sample(), fs);
        end
    endtask

    // Wait until every predicted item has arrived and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(vss_pkg::cfg_reg_t idx, logic [12:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Stimulus sequence.
    initial
    begin
        logic signed [15:0] ux_v;
        logic signed [15:0] uy_v;
        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = vss_pkg::REG_FRAME_COLS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        ux_sample    = '0;
        uy_sample    = '0;
        frame_start  = 1'b0;
        out_ready    = 1'b0;
        gaps_on      = 1'b1;
        stall_left   = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset frame size: the start of the first row, which completes no cell.
        send_frames(0, 40, 1'b1);
        settle();

        // Smallest frame, curl driven to both extremes; the second frame starts by wrap.
        write_reg(vss_pkg::REG_FRAME_COLS, 13'd3);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd3);
        for (int f = 0; f < 2; f++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (r == 0)
                        ux_v = f ? SAMPLE_MAX : SAMPLE_MIN;
                    else if (r == 2)
                        ux_v = f ? SAMPLE_MIN : SAMPLE_MAX;
                    else
                        ux_v = pick_sample();
                    if (r == 1 && c == 0)
                        uy_v = f ? SAMPLE_MIN : SAMPLE_MAX;
                    else if (r == 1 && c == 2)
                        uy_v = f ? SAMPLE_MAX : SAMPLE_MIN;
                    else
                        uy_v = pick_sample();
                    send_item(ux_v, uy_v, f == 0 && r == 0 && c == 0);
                end
            end
        end
        // Frame restarted part-way through its second row.
        for (int i = 0; i < 13; i++)
            send_item(pick_sample(), pick_sample(), i == 4);
        settle();

        // Sizes below the minimum, with a column value whose upper data bits are set.
        write_reg(vss_pkg::REG_FRAME_COLS, 13'h1800);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd2);
        send_frames(3, 0, 1'b1);
        settle();

        // Widest row, column register above the limit: the start of the first row.
        write_reg(vss_pkg::REG_FRAME_COLS, 13'd2047);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd3);
        send_frames(0, 200, 1'b1);
        settle();

        // Tall frame, row register above the limit: its first forty rows.
        write_reg(vss_pkg::REG_FRAME_COLS, 13'd3);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd8191);
        send_frames(0, 120, 1'b1);
        settle();

        // Random small frames followed by stray items with occasional early restarts.
        for (int p = 0; p < 6; p++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            write_reg(vss_pkg::REG_FRAME_COLS, 13'($urandom_range(3, 12)));
            write_reg(vss_pkg::REG_FRAME_ROWS, 13'($urandom_range(3, 8)));
            send_frames($urandom_range(1, 2), $urandom_range(0, 10), 1'b1);
            repeat ($urandom_range(0, 20))
                send_item(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
            settle();
        end

        // Frame shrunk while the counters sit beyond the new row and row count.
        gaps_on = 1'b1;
        write_reg(vss_pkg::REG_FRAME_COLS, 13'd20);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd6);
        send_frames(1, 3 * 20 + 13, 1'b1);
        settle();
        write_reg(vss_pkg::REG_FRAME_COLS, 13'd7);
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'd3);
        send_frames(2, 5, 1'b0);
        settle();

        // Closing stretch at full rate on both sides.
        gaps_on = 1'b0;
        write_reg(vss_pkg::REG_FRAME_COLS, 13'($urandom_range(3, 16)));
        write_reg(vss_pkg::REG_FRAME_ROWS, 13'($urandom_range(3, 8)));
        send_frames(2, 0, 1'b1);
        settle();

        if (sb.errors == 0)
            $display("vorticity_stencil_stream verification clean");
        else
            $display("vorticity_stencil_stream verification failed");
        $finish;
    end

endmodule
